@@ hdl/dwg_pkg.sv @@
// Shared types, constants and waveform tables for the DAC waveform generator.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package dwg_pkg;

  localparam int WAVE_SAMPLES = 128;
  localparam int SAMPLE_IDX_W = $clog2(WAVE_SAMPLES);
  localparam int HALF         = WAVE_SAMPLES / 2;
  localparam int HALF_M1      = HALF - 1;
  localparam int CODE_W       = 12;
  localparam int CODE_MAX     = 4095;
  localparam int COUNT_W      = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  typedef logic [CODE_W-1:0]       code_t;
  typedef logic [COUNT_W-1:0]      count_t;
  typedef logic [SAMPLE_IDX_W-1:0] sample_idx_t;

  typedef enum logic [1:0] {
    WAVE_DC       = 2'd0,
    WAVE_SINE     = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SQUARE   = 2'd3
  } wave_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WAVE_MODE     = 2'd0,
    REG_DC_LEVEL      = 2'd1,
    REG_PRESCALE_DIV  = 2'd2,
    REG_PERIOD_RELOAD = 2'd3
  } cfg_reg_t;

  // Timebase status handed to the top level for the tick being transferred
  typedef struct packed {
    logic        update;
    sample_idx_t sample_index;
  } tick_t;

  // One result item as held in the output stages
  typedef struct packed {
    code_t sample_code;
    logic  update_strobe;
    logic  output_active;
  } result_t;

  typedef code_t sine_table_t [WAVE_SAMPLES];
  typedef code_t tri_table_t  [HALF];

  localparam sine_table_t SINE_TABLE = '{
    12'd2048, 12'd2148, 12'd2248, 12'd2348, 12'd2447, 12'd2545, 12'd2642, 12'd2737,
    12'd2831, 12'd2923, 12'd3013, 12'd3100, 12'd3185, 12'd3267, 12'd3346, 12'd3423,
    12'd3495, 12'd3565, 12'd3630, 12'd3692, 12'd3750, 12'd3804, 12'd3853, 12'd3898,
    12'd3939, 12'd3975, 12'd4007, 12'd4034, 12'd4056, 12'd4073, 12'd4085, 12'd4093,
    12'd4095, 12'd4093, 12'd4085, 12'd4073, 12'd4056, 12'd4034, 12'd4007, 12'd3975,
    12'd3939, 12'd3898, 12'd3853, 12'd3804, 12'd3750, 12'd3692, 12'd3630, 12'd3565,
    12'd3495, 12'd3423, 12'd3346, 12'd3267, 12'd3185, 12'd3100, 12'd3013, 12'd2923,
    12'd2831, 12'd2737, 12'd2642, 12'd2545, 12'd2447, 12'd2348, 12'd2248, 12'd2148,
    12'd2048, 12'd1947, 12'd1847, 12'd1747, 12'd1648, 12'd1550, 12'd1453, 12'd1358,
    12'd1264, 12'd1172, 12'd1082, 12'd995,  12'd910,  12'd828,  12'd749,  12'd672,
    12'd600,  12'd530,  12'd465,  12'd403,  12'd345,  12'd291,  12'd242,  12'd197,
    12'd156,  12'd120,  12'd88,   12'd61,   12'd39,   12'd22,   12'd10,   12'd2,
    12'd0,    12'd2,    12'd10,   12'd22,   12'd39,   12'd61,   12'd88,   12'd120,
    12'd156,  12'd197,  12'd242,  12'd291,  12'd345,  12'd403,  12'd465,  12'd530,
    12'd600,  12'd672,  12'd749,  12'd828,  12'd910,  12'd995,  12'd1082, 12'd1172,
    12'd1264, 12'd1358, 12'd1453, 12'd1550, 12'd1648, 12'd1747, 12'd1847, 12'd1947
  };

  // Rising half of the triangle, floor(i * CODE_MAX / HALF_M1), built at elaboration
  function automatic tri_table_t build_tri_table();
    tri_table_t t;
    for (int i = 0; i < HALF; i++) begin
      t[i] = CODE_W'((i * CODE_MAX) / HALF_M1);
    end
    return t;
  endfunction

  localparam tri_table_t TRI_TABLE = build_tri_table();

endpackage

@@ hdl/dwg_if.sv @@
// Valid/ready channel interfaces for the DAC waveform generator.
// Depends on dwg_pkg for the code width.
interface dwg_in_if;
  logic valid;
  logic ready;
  logic run;

  modport source (output valid, output run, input ready);
  modport sink   (input valid, input run, output ready);
endinterface

interface dwg_out_if;
  logic                valid;
  logic                ready;
  dwg_pkg::code_t      sample_code;
  logic                update_strobe;
  logic                output_active;

  modport source (output valid, output sample_code, output update_strobe,
                  output output_active, input ready);
  modport sink   (input valid, input sample_code, input update_strobe,
                  input output_active, output ready);
endinterface

@@ hdl/dwg_timebase.sv @@
// Prescaler, period counter and sample index; flags the update event of a tick.
// Depends on dwg_pkg.
module dwg_timebase (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic            run,
  input  dwg_pkg::count_t prescale_div,
  input  dwg_pkg::count_t period_reload,
  output dwg_pkg::tick_t  tick
);

  dwg_pkg::count_t      prescale_count;
  dwg_pkg::count_t      prescale_count_next;
  dwg_pkg::count_t      period_count;
  dwg_pkg::count_t      period_count_next;
  dwg_pkg::sample_idx_t sample_index;
  dwg_pkg::sample_idx_t sample_index_next;
  logic                 prescale_wrap;
  logic                 period_wrap;

  // a count at or above its limit wraps, which also covers a lowered limit
  assign prescale_wrap = prescale_count >= prescale_div;
  assign period_wrap   = period_count >= period_reload;

  assign tick.update       = run & prescale_wrap & period_wrap;
  assign tick.sample_index = sample_index;

  always_comb begin
    prescale_count_next = prescale_count;
    period_count_next   = period_count;
    sample_index_next   = sample_index;
    if (!run) begin
      prescale_count_next = '0;
      period_count_next   = '0;
      sample_index_next   = '0;
    end else begin
      if (prescale_wrap) begin
        prescale_count_next = '0;
        if (period_wrap) begin
          period_count_next = '0;
        end else begin
          period_count_next = period_count + 1'b1;
        end
      end else begin
        prescale_count_next = prescale_count + 1'b1;
      end
      if (tick.update) begin
        sample_index_next = sample_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      period_count   <= '0;
      sample_index   <= '0;
    end else if (fire) begin
      prescale_count <= prescale_count_next;
      period_count   <= period_count_next;
      sample_index   <= sample_index_next;
    end
  end

endmodule

@@ hdl/dwg_wave_lut.sv @@
// Waveform code lookup: sine table, mirrored triangle and square.
// Depends on dwg_pkg for the tables and mode codes.
module dwg_wave_lut (
  input  dwg_pkg::wave_mode_t  wave_mode,
  input  dwg_pkg::sample_idx_t sample_index,
  output dwg_pkg::code_t       wave_code
);

  logic                                second_half;
  logic [dwg_pkg::SAMPLE_IDX_W-2:0]    half_index;
  dwg_pkg::code_t                      tri_rise;

  assign second_half = sample_index[dwg_pkg::SAMPLE_IDX_W-1];
  assign half_index  = sample_index[dwg_pkg::SAMPLE_IDX_W-2:0];
  assign tri_rise    = dwg_pkg::TRI_TABLE[half_index];

  always_comb begin
    unique case (wave_mode)
      dwg_pkg::WAVE_SINE:     wave_code = dwg_pkg::SINE_TABLE[sample_index];
      // falling half mirrors the rising one
      dwg_pkg::WAVE_TRIANGLE: wave_code = second_half
                                ? dwg_pkg::code_t'(dwg_pkg::CODE_MAX) - tri_rise
                                : tri_rise;
      dwg_pkg::WAVE_SQUARE:   wave_code = second_half
                                ? '0 : dwg_pkg::code_t'(dwg_pkg::CODE_MAX);
      default:                wave_code = '0;
    endcase
  end

endmodule

@@ hdl/dwg_out_skid.sv @@
// Output register with a skid stage, so a tick can be taken while a result waits.
// Depends on dwg_pkg and dwg_out_if.
module dwg_out_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dwg_pkg::result_t push_data,
  output logic             push_ready,
  dwg_out_if.source        out_ch
);

  logic             main_valid;
  dwg_pkg::result_t main_data;
  logic             skid_valid;
  dwg_pkg::result_t skid_data;
  logic             pop;

  assign push_ready = !skid_valid;
  assign pop        = main_valid & out_ch.ready;

  assign out_ch.valid         = main_valid;
  assign out_ch.sample_code   = main_data.sample_code;
  assign out_ch.update_strobe = main_data.update_strobe;
  assign out_ch.output_active = main_data.output_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

@@ hdl/dac_waveform_generator.sv @@
// Top level of the timer-paced 12-bit DAC code generator.
// Depends on dwg_pkg, dwg_if, dwg_timebase, dwg_wave_lut and dwg_out_skid.
//
//   channel   dir  transfer carries
//   in_ch     in   run, one timer tick
//   out_ch    out  sample_code, update_strobe, output_active
//   cfg_*     in   wave_mode, dc_level, prescale_div, period_reload
//
// One tick is taken every cycle while the skid stage is free; its result is registered in the output stage.
// Counter compare, table lookup and held-code select are combinational, in the same cycle as the tick.
// A two-entry output stage (register plus skid) keeps in_ch ready through a stall until the skid is full.
// Synchronous reset clears counters, index, held code and registers; no clearing pass.
module dac_waveform_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [dwg_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [dwg_pkg::CFG_DATA_W-1:0]        cfg_data,
  dwg_in_if.sink                                in_ch,
  dwg_out_if.source                             out_ch
);

  dwg_pkg::wave_mode_t wave_mode;
  dwg_pkg::code_t      dc_level;
  dwg_pkg::count_t     prescale_div;
  dwg_pkg::count_t     period_reload;
  dwg_pkg::code_t      held_code;
  dwg_pkg::code_t      held_code_next;
  dwg_pkg::code_t      wave_code;
  dwg_pkg::tick_t      tick;
  dwg_pkg::result_t    push_data;
  logic                push_ready;
  logic                fire;

  assign in_ch.ready = push_ready;
  assign fire        = in_ch.valid & push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode     <= dwg_pkg::WAVE_DC;
      dc_level      <= '0;
      prescale_div  <= '0;
      period_reload <= '0;
    end else if (cfg_wr_en) begin
      unique case (dwg_pkg::cfg_reg_t'(cfg_index))
        dwg_pkg::REG_WAVE_MODE:     wave_mode     <= dwg_pkg::wave_mode_t'(cfg_data[1:0]);
        dwg_pkg::REG_DC_LEVEL:      dc_level      <= cfg_data[dwg_pkg::CODE_W-1:0];
        dwg_pkg::REG_PRESCALE_DIV:  prescale_div  <= cfg_data[dwg_pkg::COUNT_W-1:0];
        dwg_pkg::REG_PERIOD_RELOAD: period_reload <= cfg_data[dwg_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  dwg_timebase u_timebase (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .run           (in_ch.run),
    .prescale_div  (prescale_div),
    .period_reload (period_reload),
    .tick          (tick)
  );

  dwg_wave_lut u_wave_lut (
    .wave_mode    (wave_mode),
    .sample_index (tick.sample_index),
    .wave_code    (wave_code)
  );

  always_comb begin
    held_code_next = held_code;
    if (in_ch.run) begin
      if (wave_mode == dwg_pkg::WAVE_DC) begin
        held_code_next = dc_level;
      end else if (tick.update) begin
        held_code_next = wave_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_code <= '0;
    end else if (fire) begin
      held_code <= held_code_next;
    end
  end

  assign push_data.sample_code   = held_code_next;
  assign push_data.update_strobe = tick.update;
  assign push_data.output_active = in_ch.run;

  dwg_out_skid u_out_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  // a stopped tick returns the sample index to the start of the period
  assert property (@(posedge clk) disable iff (rst)
    fire && !in_ch.run |=> tick.sample_index == '0)
    else $error("sample index not cleared after a stopped tick");

  // dc mode loads the held code from the level register on every running tick
  assert property (@(posedge clk) disable iff (rst)
    fire && in_ch.run && wave_mode == dwg_pkg::WAVE_DC && !cfg_wr_en
      |=> held_code == $past(dc_level))
    else $error("held code does not follow dc level");

  // an update event only comes from a running tick
  assert property (@(posedge clk) disable iff (rst)
    push_data.update_strobe |-> push_data.output_active)
    else $error("update event on a stopped tick");
`endif

endmodule

@@ bench/tb.sv @@
// Self-checking bench for dac_waveform_generator: directed ticks, then random phases.
// Depends on dwg_pkg and the channel interfaces in dwg_if; keeps its own copy of the timebase.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TICKS = 1150;
  localparam int QUIET_LIMIT  = 1000;

  typedef struct {
    dwg_pkg::code_t code;
    logic           strobe;
    logic           active;
  } dac_sample_t;

  localparam dwg_pkg::code_t SINE_CODES [128] = '{
    12'd2048, 12'd2148, 12'd2248, 12'd2348, 12'd2447, 12'd2545, 12'd2642, 12'd2737,
    12'd2831, 12'd2923, 12'd3013, 12'd3100, 12'd3185, 12'd3267, 12'd3346, 12'd3423,
    12'd3495, 12'd3565, 12'd3630, 12'd3692, 12'd3750, 12'd3804, 12'd3853, 12'd3898,
    12'd3939, 12'd3975, 12'd4007, 12'd4034, 12'd4056, 12'd4073, 12'd4085, 12'd4093,
    12'd4095, 12'd4093, 12'd4085, 12'd4073, 12'd4056, 12'd4034, 12'd4007, 12'd3975,
    12'd3939, 12'd3898, 12'd3853, 12'd3804, 12'd3750, 12'd3692, 12'd3630, 12'd3565,
    12'd3495, 12'd3423, 12'd3346, 12'd3267, 12'd3185, 12'd3100, 12'd3013, 12'd2923,
    12'd2831, 12'd2737, 12'd2642, 12'd2545, 12'd2447, 12'd2348, 12'd2248, 12'd2148,
    12'd2048, 12'd1947, 12'd1847, 12'd1747, 12'd1648, 12'd1550, 12'd1453, 12'd1358,
    12'd1264, 12'd1172, 12'd1082, 12'd995,  12'd910,  12'd828,  12'd749,  12'd672,
    12'd600,  12'd530,  12'd465,  12'd403,  12'd345,  12'd291,  12'd242,  12'd197,
    12'd156,  12'd120,  12'd88,   12'd61,   12'd39,   12'd22,   12'd10,   12'd2,
    12'd0,    12'd2,    12'd10,   12'd22,   12'd39,   12'd61,   12'd88,   12'd120,
    12'd156,  12'd197,  12'd242,  12'd291,  12'd345,  12'd403,  12'd465,  12'd530,
    12'd600,  12'd672,  12'd749,  12'd828,  12'd910,  12'd995,  12'd1082, 12'd1172,
    12'd1264, 12'd1358, 12'd1453, 12'd1550, 12'd1648, 12'd1747, 12'd1847, 12'd1947
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [dwg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dwg_pkg::CFG_DATA_W-1:0]  cfg_data;

  dwg_in_if  in_ch ();
  dwg_out_if out_ch ();

  dac_waveform_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Timebase copy and its registers
  dwg_pkg::wave_mode_t  cfg_mode;
  dwg_pkg::code_t       cfg_dc;
  dwg_pkg::count_t      cfg_presc;
  dwg_pkg::count_t      cfg_period;
  dwg_pkg::count_t      presc_cnt;
  dwg_pkg::count_t      period_cnt;
  dwg_pkg::sample_idx_t wave_idx;
  dwg_pkg::code_t       held;

  dac_sample_t pending_samples [$];
  dac_sample_t due;

  bit send_gaps;
  bit sink_stalls;
  int out_hold;
  int quiet;
  int n_ticks;
  int n_samples;
  int n_updates;
  int n_writes;
  int n_errors;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic dwg_pkg::code_t wave_lookup(dwg_pkg::wave_mode_t m,
                                                 dwg_pkg::sample_idx_t i);
    int k;
    k = int'(i);
    case (m)
      dwg_pkg::WAVE_SINE:     return SINE_CODES[i];
      dwg_pkg::WAVE_TRIANGLE: begin
        if (k < 64) return dwg_pkg::code_t'((k * 4095) / 63);
        return dwg_pkg::code_t'(4095 - ((k - 64) * 4095) / 63);
      end
      default:       return (k < 64) ? dwg_pkg::code_t'(4095) : dwg_pkg::code_t'(0);
    endcase
  endfunction

  function automatic void predict_tick(bit run_v);
    dac_sample_t s;
    bit upd;
    upd = 1'b0;
    if (!run_v) begin
      presc_cnt  = '0;
      period_cnt = '0;
      wave_idx   = '0;
    end else begin
      // a count at or above its limit wraps, even after the limit was lowered
      if (presc_cnt >= cfg_presc) begin
        presc_cnt = '0;
        if (period_cnt >= cfg_period) begin
          period_cnt = '0;
          upd = 1'b1;
        end else begin
          period_cnt = period_cnt + 1'b1;
        end
      end else begin
        presc_cnt = presc_cnt + 1'b1;
      end
      if (cfg_mode == dwg_pkg::WAVE_DC) held = cfg_dc;
      else if (upd) held = wave_lookup(cfg_mode, wave_idx);
      if (upd) wave_idx = wave_idx + 1'b1;
    end
    s.code   = held;
    s.strobe = upd;
    s.active = run_v;
    pending_samples.push_back(s);
    n_updates += upd;
  endfunction

  function automatic void check_field(string field, int exp_v, int act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
    end
  endfunction

  // Sink side: compare each transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready) begin
      n_samples++;
      if (pending_samples.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none actual code %0d", $time,
                 out_ch.sample_code);
      end else begin
        due = pending_samples.pop_front();
        check_field("sample_code", int'(due.code), int'(out_ch.sample_code));
        check_field("update_strobe", int'(due.strobe), int'(out_ch.update_strobe));
        check_field("output_active", int'(due.active), int'(out_ch.output_active));
      end
      out_hold = sink_stalls ? $urandom_range(0, 7) : 0;
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ch.ready = 1'b0;
      out_hold--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("tb failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_tick(input bit run_v);
    int gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.run   = run_v;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predict_tick(run_v);
    n_ticks++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input dwg_pkg::cfg_reg_t idx, input int unsigned value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value[dwg_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      dwg_pkg::REG_WAVE_MODE:    cfg_mode   = dwg_pkg::wave_mode_t'(value[1:0]);
      dwg_pkg::REG_DC_LEVEL:     cfg_dc     = value[dwg_pkg::CODE_W-1:0];
      dwg_pkg::REG_PRESCALE_DIV: cfg_presc  = value[dwg_pkg::COUNT_W-1:0];
      default:                   cfg_period = value[dwg_pkg::COUNT_W-1:0];
    endcase
    n_writes++;
  endtask

  task automatic send_run(input int count);
    repeat (count) send_tick(1'b1);
  endtask

  // All registers at zero: dc mode, an update on every running tick
  task automatic test_after_reset();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();
  endtask

  // Stopped ticks hold the last running code
  task automatic test_dc_level();
    write_reg(dwg_pkg::REG_DC_LEVEL, 4095);
    send_run(2);
    send_tick(1'b0);
    wait_idle();
  endtask

  // After run rises the held code stays until the first update loads sample 0
  task automatic test_first_sample();
    write_reg(dwg_pkg::REG_WAVE_MODE, dwg_pkg::WAVE_TRIANGLE);
    write_reg(dwg_pkg::REG_PRESCALE_DIV, 1);
    write_reg(dwg_pkg::REG_PERIOD_RELOAD, 1);
    send_tick(1'b0);
    send_run(6);
    wait_idle();
  endtask

  // Lower a limit below a running count; the count must wrap on the next tick
  task automatic test_count_above_limit();
    write_reg(dwg_pkg::REG_WAVE_MODE, dwg_pkg::WAVE_SQUARE);
    write_reg(dwg_pkg::REG_PRESCALE_DIV, 9);
    write_reg(dwg_pkg::REG_PERIOD_RELOAD, 0);
    send_tick(1'b0);
    send_run(4);
    wait_idle();
    write_reg(dwg_pkg::REG_PRESCALE_DIV, 2);
    send_run(2);
    wait_idle();
    write_reg(dwg_pkg::REG_WAVE_MODE, dwg_pkg::WAVE_SINE);
    write_reg(dwg_pkg::REG_PRESCALE_DIV, 0);
    write_reg(dwg_pkg::REG_PERIOD_RELOAD, 9);
    send_run(4);
    wait_idle();
    write_reg(dwg_pkg::REG_PERIOD_RELOAD, 1);
    send_run(2);
    wait_idle();
    write_reg(dwg_pkg::REG_PERIOD_RELOAD, 65535);
    write_reg(dwg_pkg::REG_PRESCALE_DIV, 65535);
    wait_idle();
    send_run(2);
    wait_idle();
  endtask

  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 3);
    if (r < 80) return $urandom_range(4, 40);
    if (r < 90) return $urandom_range(0, 65535);
    return (r < 95) ? 0 : 65535;
  endfunction

  task automatic test_random_phases();
    int sent;
    int count;
    int low_pct;
    int unsigned r;
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      r = $urandom_range(0, 3);
      send_gaps   = r[0];
      sink_stalls = r[1];
      write_reg(dwg_pkg::REG_WAVE_MODE, $urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 9);
        write_reg(dwg_pkg::REG_DC_LEVEL,
                  (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 4095));
      end
      if ($urandom_range(0, 3) == 0) begin
        // fast timebase, long enough to sweep the whole table at a period reload of 0
        write_reg(dwg_pkg::REG_PRESCALE_DIV, 0);
        write_reg(dwg_pkg::REG_PERIOD_RELOAD, $urandom_range(0, 1));
        count   = $urandom_range(140, 260);
        low_pct = 0;
      end else begin
        if ($urandom_range(0, 2) != 0) write_reg(dwg_pkg::REG_PRESCALE_DIV, pick_count());
        if ($urandom_range(0, 2) != 0) write_reg(dwg_pkg::REG_PERIOD_RELOAD, pick_count());
        count = $urandom_range(20, 80);
        r = $urandom_range(0, 2);
        low_pct = (r == 0) ? 0 : (r == 1) ? 5 : 30;
      end
      // trim the last phase to the tick budget
      if (count > RANDOM_TICKS - sent) count = RANDOM_TICKS - sent;
      repeat (count) send_tick($urandom_range(0, 99) >= low_pct);
      sent += count;
      wait_idle();
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.run   = 1'b0;
    out_ch.ready = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = dwg_pkg::REG_WAVE_MODE;
    cfg_data    = '0;
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    out_hold    = 0;
    quiet       = 0;
    n_ticks     = 0;
    n_samples   = 0;
    n_updates   = 0;
    n_writes    = 0;
    n_errors    = 0;
    cfg_mode    = dwg_pkg::WAVE_DC;
    cfg_dc      = '0;
    cfg_presc   = '0;
    cfg_period  = '0;
    presc_cnt   = '0;
    period_cnt  = '0;
    wave_idx    = '0;
    held        = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_after_reset();
    test_dc_level();
    test_first_sample();
    test_count_above_limit();
    test_random_phases();

    wait_idle();
    repeat (5) @(negedge clk);
    $display("Covered %0d ticks and %0d results, %0d of them update events,", n_ticks,
             n_samples, n_updates);
    $display("across %0d register writes in all four wave modes.", n_writes);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
